// ===== rtl/gradient_noise_3d_core_macros.svh =====
// Assertion macros shared by the gradient noise core.
// Used by gradient_noise_3d_core; no other dependencies.
`ifndef GRADIENT_NOISE_3D_CORE_MACROS_SVH
`define GRADIENT_NOISE_3D_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is held
`define GN3_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held
`define GN3_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/gn3_pkg.sv =====
// Shared noise core constants: permutation ROM, gradient codes, output format.
// No dependencies.
`timescale 1ns / 1ps

package gn3_pkg;

    localparam int OUT_FRAC = 16;
    localparam int OUT_W    = 19;
    localparam int OUT_MAX  = 131072;
    localparam int OUT_MIN  = -131072;

    // Gradient select codes (low nibble of a corner hash)
    typedef enum logic [3:0] {
        G_PXPY = 4'h0, G_NXPY = 4'h1, G_PXNY = 4'h2, G_NXNY = 4'h3,
        G_PXPZ = 4'h4, G_NXPZ = 4'h5, G_PXNZ = 4'h6, G_NXNZ = 4'h7,
        G_PYPZ = 4'h8, G_NYPZ = 4'h9, G_PYNZ = 4'hA, G_NYNZ = 4'hB,
        G_PYPX = 4'hC, G_NYPZ2 = 4'hD, G_PYNX = 4'hE, G_NYNZ2 = 4'hF
    } grad_sel_t;

    localparam logic [7:0] PERM [256] = '{
        8'd151,8'd160,8'd137,8'd91,8'd90,8'd15,8'd131,8'd13,
        8'd201,8'd95,8'd96,8'd53,8'd194,8'd233,8'd7,8'd225,
        8'd140,8'd36,8'd103,8'd30,8'd69,8'd142,8'd8,8'd99,
        8'd37,8'd240,8'd21,8'd10,8'd23,8'd190,8'd6,8'd148,
        8'd247,8'd120,8'd234,8'd75,8'd0,8'd26,8'd197,8'd62,
        8'd94,8'd252,8'd219,8'd203,8'd117,8'd35,8'd11,8'd32,
        8'd57,8'd177,8'd33,8'd88,8'd237,8'd149,8'd56,8'd87,
        8'd174,8'd20,8'd125,8'd136,8'd171,8'd168,8'd68,8'd175,
        8'd74,8'd165,8'd71,8'd134,8'd139,8'd48,8'd27,8'd166,
        8'd77,8'd146,8'd158,8'd231,8'd83,8'd111,8'd229,8'd122,
        8'd60,8'd211,8'd133,8'd230,8'd220,8'd105,8'd92,8'd41,
        8'd55,8'd46,8'd245,8'd40,8'd244,8'd102,8'd143,8'd54,
        8'd65,8'd25,8'd63,8'd161,8'd1,8'd216,8'd80,8'd73,
        8'd209,8'd76,8'd132,8'd187,8'd208,8'd89,8'd18,8'd169,
        8'd200,8'd196,8'd135,8'd130,8'd116,8'd188,8'd159,8'd86,
        8'd164,8'd100,8'd109,8'd198,8'd173,8'd186,8'd3,8'd64,
        8'd52,8'd217,8'd226,8'd250,8'd124,8'd123,8'd5,8'd202,
        8'd38,8'd147,8'd118,8'd126,8'd255,8'd82,8'd85,8'd212,
        8'd207,8'd206,8'd59,8'd227,8'd47,8'd16,8'd58,8'd17,
        8'd182,8'd189,8'd28,8'd42,8'd223,8'd183,8'd170,8'd213,
        8'd119,8'd248,8'd152,8'd2,8'd44,8'd154,8'd163,8'd70,
        8'd221,8'd153,8'd101,8'd155,8'd167,8'd43,8'd172,8'd9,
        8'd129,8'd22,8'd39,8'd253,8'd19,8'd98,8'd108,8'd110,
        8'd79,8'd113,8'd224,8'd232,8'd178,8'd185,8'd112,8'd104,
        8'd218,8'd246,8'd97,8'd228,8'd251,8'd34,8'd242,8'd193,
        8'd238,8'd210,8'd144,8'd12,8'd191,8'd179,8'd162,8'd241,
        8'd81,8'd51,8'd145,8'd235,8'd249,8'd14,8'd239,8'd107,
        8'd49,8'd192,8'd214,8'd31,8'd181,8'd199,8'd106,8'd157,
        8'd184,8'd84,8'd204,8'd176,8'd115,8'd121,8'd50,8'd45,
        8'd127,8'd4,8'd150,8'd254,8'd138,8'd236,8'd205,8'd93,
        8'd222,8'd114,8'd67,8'd29,8'd24,8'd72,8'd243,8'd141,
        8'd128,8'd195,8'd78,8'd66,8'd215,8'd61,8'd156,8'd180
    };

endpackage

// ===== rtl/gn3_fade.sv =====
// Three-stage quintic fade 6t^5-15t^4+10t^3 for one axis fraction.
// Depends on nothing; stage loads come from the top-level flow control.
`timescale 1ns / 1ps

module gn3_fade #(
    parameter int FRAC_BITS = 16
) (
    input  logic                 aclk,
    input  logic [3:1]           ld,
    input  logic [FRAC_BITS-1:0] t_in,
    output logic [FRAC_BITS:0]   fade_out
);
    localparam int F = FRAC_BITS;

    logic [2*F-1:0] tsq_reg;
    logic [2*F+3:0] bq_reg;
    logic [F-1:0]   t1_reg;
    logic [2*F-1:0] t3p_reg;
    logic [F+3:0]   bval_reg;
    logic [2*F+3:0] fprod_reg;
    logic [F+3:0]   k15;

    // stage 1: t*t and (15 - 6t)*t
    assign k15 = (F+4)'(15 << F) - (F+4)'(t_in) * (F+4)'(6);
    always_ff @(posedge aclk) begin
        if (ld[1]) begin
            tsq_reg <= t_in * t_in;
            bq_reg  <= k15 * (2*F+4)'(t_in);
            t1_reg  <= t_in;
        end
    end

    // stage 2: t^3 product and the quadratic factor
    always_ff @(posedge aclk) begin
        if (ld[2]) begin
            t3p_reg  <= tsq_reg[2*F-1:F] * t1_reg;
            bval_reg <= (F+4)'(10 << F) - bq_reg[2*F+3:F];
        end
    end

    // stage 3: t^3 * b
    always_ff @(posedge aclk) begin
        if (ld[3]) begin
            fprod_reg <= (2*F+4)'(t3p_reg[2*F-1:F]) * (2*F+4)'(bval_reg);
        end
    end

    assign fade_out = fprod_reg[2*F:F];

endmodule

// ===== rtl/gn3_hash.sv =====
// Three-stage corner hash through the permutation ROM.
// Depends on gn3_pkg for the ROM.
`timescale 1ns / 1ps

module gn3_hash (
    input  logic       aclk,
    input  logic [3:1] ld,
    input  logic [7:0] cx,
    input  logic [7:0] cy,
    input  logic [7:0] cz,
    output logic [3:0] h_out [8]
);
    logic [8:0] a_reg, b_reg;
    logic [7:0] cz1_reg;
    logic [8:0] aa_reg, ab_reg, ba_reg, bb_reg;
    logic [7:0] cx1;
    logic [7:0] ai1, bi1, aa1, ab1, ba1, bb1;

    // stage 1: first level
    assign cx1 = cx + 8'd1;
    always_ff @(posedge aclk) begin
        if (ld[1]) begin
            a_reg   <= {1'b0, gn3_pkg::PERM[cx]}  + {1'b0, cy};
            b_reg   <= {1'b0, gn3_pkg::PERM[cx1]} + {1'b0, cy};
            cz1_reg <= cz;
        end
    end

    // stage 2: second level, four rows
    assign ai1 = a_reg[7:0] + 8'd1;
    assign bi1 = b_reg[7:0] + 8'd1;
    always_ff @(posedge aclk) begin
        if (ld[2]) begin
            aa_reg <= {1'b0, gn3_pkg::PERM[a_reg[7:0]]} + {1'b0, cz1_reg};
            ab_reg <= {1'b0, gn3_pkg::PERM[ai1]}        + {1'b0, cz1_reg};
            ba_reg <= {1'b0, gn3_pkg::PERM[b_reg[7:0]]} + {1'b0, cz1_reg};
            bb_reg <= {1'b0, gn3_pkg::PERM[bi1]}        + {1'b0, cz1_reg};
        end
    end

    // stage 3: eight corner hashes, corner index = i + 2j + 4k
    assign aa1 = aa_reg[7:0] + 8'd1;
    assign ab1 = ab_reg[7:0] + 8'd1;
    assign ba1 = ba_reg[7:0] + 8'd1;
    assign bb1 = bb_reg[7:0] + 8'd1;
    always_ff @(posedge aclk) begin
        if (ld[3]) begin
            h_out[0] <= gn3_pkg::PERM[aa_reg[7:0]][3:0];
            h_out[1] <= gn3_pkg::PERM[ba_reg[7:0]][3:0];
            h_out[2] <= gn3_pkg::PERM[ab_reg[7:0]][3:0];
            h_out[3] <= gn3_pkg::PERM[bb_reg[7:0]][3:0];
            h_out[4] <= gn3_pkg::PERM[aa1][3:0];
            h_out[5] <= gn3_pkg::PERM[ba1][3:0];
            h_out[6] <= gn3_pkg::PERM[ab1][3:0];
            h_out[7] <= gn3_pkg::PERM[bb1][3:0];
        end
    end

endmodule

// ===== rtl/gn3_blend.sv =====
// Trilinear blend pipeline (x, y, z lerps) plus output scaling and clamp.
// Depends on gn3_pkg for the output format.
`timescale 1ns / 1ps

module gn3_blend #(
    parameter int FRAC_BITS = 16
) (
    input  logic                          aclk,
    input  logic [8:5]                    ld,
    input  logic signed [FRAC_BITS+2:0]   g_in [8],
    input  logic [FRAC_BITS:0]            u_in,
    input  logic [FRAC_BITS:0]            v_in,
    input  logic [FRAC_BITS:0]            w_in,
    output logic [gn3_pkg::OUT_W-1:0]     noise_out
);
    localparam int F   = FRAC_BITS;
    localparam int GW  = F + 3;
    localparam int DW  = F + 4;
    localparam int PW  = 2 * F + 6;
    localparam int SW  = (GW > 20) ? GW : 20;
    localparam int SHR = (F >= gn3_pkg::OUT_FRAC) ? F - gn3_pkg::OUT_FRAC : 0;
    localparam int SHL = (F < gn3_pkg::OUT_FRAC) ? gn3_pkg::OUT_FRAC - F : 0;

    logic signed [PW-1:0] px_reg [4];
    logic signed [GW-1:0] bx_reg [4];
    logic [F:0]           v5_reg, w5_reg, w6_reg;
    logic signed [GW-1:0] lx [4];
    logic signed [PW-1:0] py_reg [2];
    logic signed [GW-1:0] by_reg [2];
    logic signed [GW-1:0] ly [2];
    logic signed [PW-1:0] pz_reg;
    logic signed [GW-1:0] bz_reg;
    logic signed [GW-1:0] r;
    logic signed [SW-1:0] rs;
    logic signed [SW-1:0] sat;

    // stage 5: x-direction products
    always_ff @(posedge aclk) begin
        if (ld[5]) begin
            for (int i = 0; i < 4; i++) begin
                px_reg[i] <= $signed({1'b0, u_in}) *
                             (DW'(g_in[2*i+1]) - DW'(g_in[2*i]));
                bx_reg[i] <= g_in[2*i];
            end
            v5_reg <= v_in;
            w5_reg <= w_in;
        end
    end

    // stage 6: finish x lerps, y-direction products
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            lx[i] = bx_reg[i] + GW'(px_reg[i] >>> F);
        end
    end
    always_ff @(posedge aclk) begin
        if (ld[6]) begin
            for (int j = 0; j < 2; j++) begin
                py_reg[j] <= $signed({1'b0, v5_reg}) *
                             (DW'(lx[2*j+1]) - DW'(lx[2*j]));
                by_reg[j] <= lx[2*j];
            end
            w6_reg <= w5_reg;
        end
    end

    // stage 7: finish y lerps, z-direction product
    always_comb begin
        for (int j = 0; j < 2; j++) begin
            ly[j] = by_reg[j] + GW'(py_reg[j] >>> F);
        end
    end
    always_ff @(posedge aclk) begin
        if (ld[7]) begin
            pz_reg <= $signed({1'b0, w6_reg}) * (DW'(ly[1]) - DW'(ly[0]));
            bz_reg <= ly[0];
        end
    end

    // stage 8: finish z lerp, move to Q2.16, clamp
    assign r  = bz_reg + GW'(pz_reg >>> F);
    assign rs = (SW'(r) >>> SHR) <<< SHL;
    always_comb begin
        sat = rs;
        if (rs > SW'(gn3_pkg::OUT_MAX)) begin
            sat = SW'(gn3_pkg::OUT_MAX);
        end else if (rs < SW'(gn3_pkg::OUT_MIN)) begin
            sat = SW'(gn3_pkg::OUT_MIN);
        end
    end
    always_ff @(posedge aclk) begin
        if (ld[8]) begin
            noise_out <= sat[gn3_pkg::OUT_W-1:0];
        end
    end

endmodule

// ===== rtl/gradient_noise_3d_core.sv =====
// Throughput: one point per cycle if m_tready; a full stage holds until the next loads.
// The eight-register depth is set by the fade multiplier chain and the three lerps.
// Reset (aresetn low, synchronous) clears the stage valid bits; data regs are not reset.
// Top level of the 3D gradient noise core: flow control, gradient stage.
// Depends on gn3_pkg, gn3_fade, gn3_hash, gn3_blend and the macros header.
`timescale 1ns / 1ps
`include "gradient_noise_3d_core_macros.svh"

module gradient_noise_3d_core #(
    parameter int FRAC_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // pos_x [31:0], pos_y [63:32], pos_z [95:64]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // noise_value [18:0], zero [23:19]
);
    localparam int F  = FRAC_BITS;
    localparam int GW = F + 3;

    logic [8:1] vld_reg;
    logic [9:1] ld;
    logic [F-1:0] tx, ty, tz;
    logic [F-1:0] fx_reg [3:1];
    logic [F-1:0] fy_reg [3:1];
    logic [F-1:0] fz_reg [3:1];
    logic [F:0]   fade_x, fade_y, fade_z;
    logic [3:0]   h [8];
    logic signed [GW-1:0] g_reg [8];
    logic [F:0]   u_reg, v_reg, w_reg;
    logic signed [GW-1:0] ox [2];
    logic signed [GW-1:0] oy [2];
    logic signed [GW-1:0] oz [2];

    // a stage loads when empty or when the stage after it moves
    always_comb begin
        ld[9] = m_tready;
        for (int k = 8; k >= 1; k--) begin
            ld[k] = !vld_reg[k] || ld[k+1];
        end
    end
    assign s_tready = ld[1];
    assign m_tvalid = vld_reg[8];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (ld[1]) begin
                vld_reg[1] <= s_tvalid;
            end
            for (int k = 2; k <= 8; k++) begin
                if (ld[k]) begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    assign tx = s_tdata[F-1:0];
    assign ty = s_tdata[32+F-1:32];
    assign tz = s_tdata[64+F-1:64];

    // fractions ride along to the gradient stage
    always_ff @(posedge aclk) begin
        for (int k = 1; k <= 3; k++) begin
            if (ld[k]) begin
                fx_reg[k] <= (k == 1) ? tx : fx_reg[(k == 1) ? 1 : k-1];
                fy_reg[k] <= (k == 1) ? ty : fy_reg[(k == 1) ? 1 : k-1];
                fz_reg[k] <= (k == 1) ? tz : fz_reg[(k == 1) ? 1 : k-1];
            end
        end
    end

    gn3_fade #(.FRAC_BITS(F)) u_fade_x (
        .aclk(aclk), .ld(ld[3:1]), .t_in(tx), .fade_out(fade_x));
    gn3_fade #(.FRAC_BITS(F)) u_fade_y (
        .aclk(aclk), .ld(ld[3:1]), .t_in(ty), .fade_out(fade_y));
    gn3_fade #(.FRAC_BITS(F)) u_fade_z (
        .aclk(aclk), .ld(ld[3:1]), .t_in(tz), .fade_out(fade_z));

    gn3_hash u_hash (
        .aclk (aclk),
        .ld   (ld[3:1]),
        .cx   (s_tdata[F+7:F]),
        .cy   (s_tdata[32+F+7:32+F]),
        .cz   (s_tdata[64+F+7:64+F]),
        .h_out(h)
    );

    // corner offsets: fraction, and fraction minus one
    assign ox[0] = GW'($signed({1'b0, fx_reg[3]}));
    assign oy[0] = GW'($signed({1'b0, fy_reg[3]}));
    assign oz[0] = GW'($signed({1'b0, fz_reg[3]}));
    assign ox[1] = ox[0] - GW'(1 << F);
    assign oy[1] = oy[0] - GW'(1 << F);
    assign oz[1] = oz[0] - GW'(1 << F);

    function automatic logic signed [GW-1:0] grad_sum(
        input logic [3:0] hc,
        input logic signed [GW-1:0] x,
        input logic signed [GW-1:0] y,
        input logic signed [GW-1:0] z
    );
        logic signed [GW-1:0] res;
        case (gn3_pkg::grad_sel_t'(hc))
            gn3_pkg::G_PXPY:  res =  x + y;
            gn3_pkg::G_NXPY:  res = -x + y;
            gn3_pkg::G_PXNY:  res =  x - y;
            gn3_pkg::G_NXNY:  res = -x - y;
            gn3_pkg::G_PXPZ:  res =  x + z;
            gn3_pkg::G_NXPZ:  res = -x + z;
            gn3_pkg::G_PXNZ:  res =  x - z;
            gn3_pkg::G_NXNZ:  res = -x - z;
            gn3_pkg::G_PYPZ:  res =  y + z;
            gn3_pkg::G_NYPZ:  res = -y + z;
            gn3_pkg::G_PYNZ:  res =  y - z;
            gn3_pkg::G_NYNZ:  res = -y - z;
            gn3_pkg::G_PYPX:  res =  y + x;
            gn3_pkg::G_NYPZ2: res = -y + z;
            gn3_pkg::G_PYNX:  res =  y - x;
            default:          res = -y - z;
        endcase
        return res;
    endfunction

    // stage 4: corner gradients and fade weights
    always_ff @(posedge aclk) begin
        if (ld[4]) begin
            for (int c = 0; c < 8; c++) begin
                g_reg[c] <= grad_sum(h[c], ox[c % 2], oy[(c / 2) % 2], oz[c / 4]);
            end
            u_reg <= fade_x;
            v_reg <= fade_y;
            w_reg <= fade_z;
        end
    end

    gn3_blend #(.FRAC_BITS(F)) u_blend (
        .aclk     (aclk),
        .ld       (ld[8:5]),
        .g_in     (g_reg),
        .u_in     (u_reg),
        .v_in     (v_reg),
        .w_in     (w_reg),
        .noise_out(m_tdata[gn3_pkg::OUT_W-1:0])
    );
    assign m_tdata[23:gn3_pkg::OUT_W] = '0;

    `GN3_ASSERT_NEXT(a_accept_fills_s1, aclk, aresetn, s_tvalid && s_tready, vld_reg[1],
        "accepted request did not reach stage 1")
    `GN3_ASSERT_NOW(a_full_when_blocked, aclk, aresetn, !s_tready, &vld_reg,
        "input blocked while a stage is empty")
    `GN3_ASSERT_NOW(a_block_needs_stall, aclk, aresetn, !s_tready, m_tvalid && !m_tready,
        "input blocked without an output stall")
    `GN3_ASSERT_NOW(a_out_range, aclk, aresetn, m_tvalid,
        ($signed(m_tdata[18:0]) <= 19'sd131072) && ($signed(m_tdata[18:0]) >= -19'sd131072),
        "result outside plus or minus two")

endmodule

// ===== sim/gradient_noise_3d_checker.sv =====
// Checker for the 3D gradient noise core: predicts each noise value from the
// accepted point and compares it with the returned result. Depends on gn3_pkg.
`timescale 1ns / 1ps

module gradient_noise_3d_checker #(
    parameter int FRAC_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [95:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,
    output int          fail_count,
    output int          pending,
    output int          result_count
);
    localparam longint ONE = longint'(1) << FRAC_BITS;

    logic [18:0] noise_fifo [$];

    function automatic longint floor_div(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint fade_curve(longint t);
        longint t2, t3, b;
        t2 = (t * t) >>> FRAC_BITS;
        t3 = (t2 * t) >>> FRAC_BITS;
        b = 10 * ONE - (((15 * ONE - 6 * t) * t) >>> FRAC_BITS);
        return (t3 * b) >>> FRAC_BITS;
    endfunction

    function automatic longint corner_grad(logic [7:0] h, longint x, longint y, longint z);
        gn3_pkg::grad_sel_t g;
        g = gn3_pkg::grad_sel_t'(h[3:0]);
        case (g)
            gn3_pkg::G_PXPY:  return  x + y;
            gn3_pkg::G_NXPY:  return -x + y;
            gn3_pkg::G_PXNY:  return  x - y;
            gn3_pkg::G_NXNY:  return -x - y;
            gn3_pkg::G_PXPZ:  return  x + z;
            gn3_pkg::G_NXPZ:  return -x + z;
            gn3_pkg::G_PXNZ:  return  x - z;
            gn3_pkg::G_NXNZ:  return -x - z;
            gn3_pkg::G_PYPZ:  return  y + z;
            gn3_pkg::G_NYPZ:  return -y + z;
            gn3_pkg::G_PYNZ:  return  y - z;
            gn3_pkg::G_NYNZ:  return -y - z;
            gn3_pkg::G_PYPX:  return  y + x;
            gn3_pkg::G_NYPZ2: return -y + z;
            gn3_pkg::G_PYNX:  return  y - x;
            default:          return -y - z;
        endcase
    endfunction

    function automatic longint lerp(longint f, longint a, longint b);
        return a + floor_div(f * (b - a), FRAC_BITS);
    endfunction

    function automatic logic [7:0] hash(int i);
        return gn3_pkg::PERM[i & 255];
    endfunction

    // Full noise evaluation for one point
    function automatic logic [18:0] noise_of(logic [95:0] d);
        logic [31:0] p [3];
        int lat [3];
        longint fr [3], fd [3];
        int a, b, aa, ab, ba, bb;
        longint nz, fz, r, x1, y1, z1;
        for (int k = 0; k < 3; k++) begin
            p[k] = d[32*k +: 32];
            lat[k] = int'((p[k] >> FRAC_BITS) & 32'hFF);
            fr[k] = longint'(p[k] & ((32'd1 << FRAC_BITS) - 1));
            fd[k] = fade_curve(fr[k]);
        end
        x1 = fr[0] - ONE; y1 = fr[1] - ONE; z1 = fr[2] - ONE;
        a = hash(lat[0]) + lat[1];
        b = hash(lat[0] + 1) + lat[1];
        aa = hash(a) + lat[2];
        ab = hash(a + 1) + lat[2];
        ba = hash(b) + lat[2];
        bb = hash(b + 1) + lat[2];
        nz = lerp(fd[1],
            lerp(fd[0], corner_grad(hash(aa), fr[0], fr[1], fr[2]),
                        corner_grad(hash(ba), x1, fr[1], fr[2])),
            lerp(fd[0], corner_grad(hash(ab), fr[0], y1, fr[2]),
                        corner_grad(hash(bb), x1, y1, fr[2])));
        fz = lerp(fd[1],
            lerp(fd[0], corner_grad(hash(aa + 1), fr[0], fr[1], z1),
                        corner_grad(hash(ba + 1), x1, fr[1], z1)),
            lerp(fd[0], corner_grad(hash(ab + 1), fr[0], y1, z1),
                        corner_grad(hash(bb + 1), x1, y1, z1)));
        r = lerp(fd[2], nz, fz);
        if (FRAC_BITS >= gn3_pkg::OUT_FRAC)
            r = floor_div(r, FRAC_BITS - gn3_pkg::OUT_FRAC);
        else
            r = r * (longint'(1) << (gn3_pkg::OUT_FRAC - FRAC_BITS));
        if (r > gn3_pkg::OUT_MAX) r = gn3_pkg::OUT_MAX;
        if (r < gn3_pkg::OUT_MIN) r = gn3_pkg::OUT_MIN;
        return r[18:0];
    endfunction

    assign pending = noise_fifo.size();

    // Predict on each accepted request, compare on each accepted result
    always @(posedge aclk) begin
        logic [18:0] want;
        if (!aresetn) begin
            fail_count <= 0;
            result_count <= 0;
        end else begin
            if (s_tvalid && s_tready)
                noise_fifo.push_back(noise_of(s_tdata));
            if (m_tvalid && m_tready) begin
                result_count <= result_count + 1;
                if (noise_fifo.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h", $time,
                             m_tdata);
                    fail_count <= fail_count + 1;
                end else begin
                    want = noise_fifo.pop_front();
                    if (m_tdata !== {5'd0, want}) begin
                        $display("%0t: noise_value mismatch, expected %h, actual %h",
                                 $time, {5'd0, want}, m_tdata);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

// ===== sim/gradient_noise_3d_core_test.sv =====
// Testbench top for the 3D gradient noise core: drives bursty points and a
// stalling result side. Depends on gradient_noise_3d_core and the checker.
`timescale 1ns / 1ps

module gradient_noise_3d_core_test;
    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [95:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [23:0] m_tdata;
    int          fail_count, pending, result_count;
    bit          stall_free;

    always #10 aclk = ~aclk;

    gradient_noise_3d_core dut (.*);
    gradient_noise_3d_checker checker_i (.*);

    // Result side stalls: alternating stretches of random and full readiness
    always @(posedge aclk) begin
        if ($urandom_range(0, 63) == 0) stall_free <= ~stall_free;
        m_tready <= stall_free ? 1'b1 : ($urandom_range(0, 3) != 0);
    end

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000 | $urandom_range(0, 3);
            1: return 32'h7FFF_FFFF - $urandom_range(0, 3);
            2: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
            3: return {16'($urandom), 16'hFFFF - 16'($urandom_range(0, 7))};
            default: return $urandom;
        endcase
    endfunction

    // One point request; waits for acceptance
    task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        s_tvalid <= 1;
        s_tdata <= {z, y, x};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic idle_gap();
        int n;
        n = $urandom_range(0, 4);
        if (n != 0) begin
            s_tvalid <= 0;
            repeat (n) @(posedge aclk);
        end
    endtask

    initial begin
        logic [31:0] edge_vals [8];
        int burst;
        edge_vals = '{32'h0, 32'h0000_FFFF, 32'h0001_0000, 32'h7FFF_FFFF,
                      32'h8000_0000, 32'hFFFF_FFFF, 32'h00FF_8000, 32'hFFFF_0001};
        repeat (11) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        // Directed: field extremes, negative coordinates, cell wrap at 255
        for (int i = 0; i < 8; i++)
            send_point(edge_vals[i], edge_vals[(i + 3) % 8], edge_vals[(i + 5) % 8]);
        for (int i = 0; i < 16; i++)
            send_point({8'h0, 8'(i * 17), 16'h8000 + 16'(i)}, 32'hFFFF_FFFF - i,
                       {16'(i), 16'hC000});
        // Random bursts
        for (int n = 0; n < 550; n += burst) begin
            burst = $urandom_range(1, 20);
            for (int k = 0; k < burst; k++)
                send_point(rand_coord(), rand_coord(), rand_coord());
            idle_gap();
        end
        s_tvalid <= 0;
        while (pending != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        $display("Checked %0d noise results: lattice extremes, negative and wrapping cells,",
                 result_count);
        $display("fraction edges and random points under bursty input and output stalls.");
        if (fail_count == 0)
            $display("[gradient_noise_3d_core] OK");
        else
            $display("[gradient_noise_3d_core] ERROR");
        $finish;
    end

    initial begin
        #2ms;
        $display("[gradient_noise_3d_core] ERROR");
        $finish;
    end
endmodule
